// ===== sv/rgm_pkg.sv =====
// ----------------------------------------------------------------------------
// rgm_pkg - shared types and constants for the Roberts gradient block
// Sizes, register indexes, the job record passed front to back, and the
// dimension clamp.
// ----------------------------------------------------------------------------
package rgm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W = 8;
  localparam int DIM_W = 11;                // config register width
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int POS_W = 10;                // result coordinate ports
  localparam int SUM_W = 2 * PIX_W + 1;     // gx^2 + gy^2
  localparam int REG_W = 1;                 // config index width

  localparam logic [REG_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [REG_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam int JOB_DEPTH = 4;             // max results per pixel
  localparam int JOB_IDX_W = $clog2(JOB_DEPTH);

  // One result to be produced by the back end. For a pass job, op_a is the
  // value; for a magnitude job the result is |a-b|,|c-d| combined.
  typedef struct packed {
    logic             mag;
    logic [PIX_W-1:0] op_a;
    logic [PIX_W-1:0] op_b;
    logic [PIX_W-1:0] op_c;
    logic [PIX_W-1:0] op_d;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             done;
  } job_t;

  // Write strobe toward the job queue
  typedef struct packed {
    logic push;
  } q_wr_t;

  // Last valid index of a dimension after clamping to 2..maxv.
  function automatic logic [COL_W-1:0] last_col_idx(input logic [DIM_W-1:0] v);
    logic [COL_W-1:0] res;
    if (v < DIM_W'(2))              res = COL_W'(1);
    else if (v > DIM_W'(MAX_WIDTH)) res = COL_W'(MAX_WIDTH - 1);
    else                            res = COL_W'(v - DIM_W'(1));
    return res;
  endfunction

  function automatic logic [ROW_W-1:0] last_row_idx(input logic [DIM_W-1:0] v);
    logic [ROW_W-1:0] res;
    if (v < DIM_W'(2))               res = ROW_W'(1);
    else if (v > DIM_W'(MAX_HEIGHT)) res = ROW_W'(MAX_HEIGHT - 1);
    else                             res = ROW_W'(v - DIM_W'(1));
    return res;
  endfunction

endpackage

// ===== sv/rgm_front.sv =====
// ----------------------------------------------------------------------------
// rgm_front - pixel intake, line buffer and job builder
// Tracks raster position, reads/writes the line buffer and turns each pixel
// into up to four jobs pushed into the job queue.
// ----------------------------------------------------------------------------
module rgm_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rgm_pkg::REG_W-1:0]   cfg_index,
  input  logic [rgm_pkg::DIM_W-1:0]   cfg_wdata,
  input  logic                        push,
  output logic                        full,
  input  logic [rgm_pkg::PIX_W-1:0]   in_pixel_in,
  output rgm_pkg::q_wr_t              q_wr,
  input  logic                        q_full,
  output rgm_pkg::job_t               q_job
);
  import rgm_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_LOAD = 3'b010,
    F_EMIT = 3'b100
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic [DIM_W-1:0] width_r, height_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [PIX_W-1:0] ul_r, left_r, up_r, pix_r;
  logic [COL_W-1:0] ce_r;
  logic [ROW_W-1:0] re_r;
  logic             lcol_r, lrow_r;

  logic [PIX_W-1:0] line_mem [MAX_WIDTH];

  job_t             jobs_r [JOB_DEPTH];
  job_t             jobs   [JOB_DEPTH];
  logic [JOB_IDX_W:0]   njob_r, njob;
  logic [JOB_IDX_W-1:0] k_r;

  logic             accept;
  logic [COL_W-1:0] lc;
  logic [ROW_W-1:0] lr;
  logic             lcol, lrow;
  logic [COL_W-1:0] ce;
  logic [ROW_W-1:0] re;
  logic             adv;

  assign accept = push && (state_r == F_IDLE);
  assign full   = (state_r != F_IDLE);

  assign lc   = last_col_idx(width_r);
  assign lr   = last_row_idx(height_r);
  assign lcol = (col_r >= lc);
  assign lrow = (row_r >= lr);
  assign ce   = lcol ? lc : col_r;
  assign re   = lrow ? lr : row_r;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(MAX_WIDTH);
      height_r <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // line buffer: read-before-write at the current column
  always_ff @(posedge clk) begin
    if (accept) begin
      up_r            <= line_mem[col_r];
      line_mem[col_r] <= in_pixel_in;
    end
  end

  // position and neighbor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ul_r   <= '0;
      left_r <= '0;
    end else begin
      if (accept) begin
        if (lcol) begin
          col_r <= '0;
          row_r <= lrow ? '0 : ROW_W'(re + ROW_W'(1));
        end else begin
          col_r <= COL_W'(ce + COL_W'(1));
          row_r <= re;
        end
      end
      if (state_r == F_LOAD) begin
        ul_r   <= up_r;
        left_r <= pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r  <= in_pixel_in;
      ce_r   <= ce;
      re_r   <= re;
      lcol_r <= lcol;
      lrow_r <= lrow;
    end
  end

  // job list for the pixel latched last cycle
  always_comb begin
    for (int i = 0; i < JOB_DEPTH; i++) jobs[i] = '0;
    njob = '0;
    if (re_r != '0 && ce_r != '0) begin
      jobs[0].mag  = (re_r != ROW_W'(1)) && (ce_r != COL_W'(1));
      jobs[0].op_a = ul_r;
      jobs[0].op_b = pix_r;
      jobs[0].op_c = up_r;
      jobs[0].op_d = left_r;
      jobs[0].row  = ROW_W'(re_r - ROW_W'(1));
      jobs[0].col  = COL_W'(ce_r - COL_W'(1));
      njob = (JOB_IDX_W+1)'(1);
      if (lrow_r) begin
        jobs[njob[JOB_IDX_W-1:0]].op_a = left_r;
        jobs[njob[JOB_IDX_W-1:0]].row  = re_r;
        jobs[njob[JOB_IDX_W-1:0]].col  = COL_W'(ce_r - COL_W'(1));
        njob = njob + (JOB_IDX_W+1)'(1);
      end
      if (lcol_r) begin
        jobs[njob[JOB_IDX_W-1:0]].op_a = up_r;
        jobs[njob[JOB_IDX_W-1:0]].row  = ROW_W'(re_r - ROW_W'(1));
        jobs[njob[JOB_IDX_W-1:0]].col  = ce_r;
        njob = njob + (JOB_IDX_W+1)'(1);
        if (lrow_r) begin
          jobs[njob[JOB_IDX_W-1:0]].op_a = pix_r;
          jobs[njob[JOB_IDX_W-1:0]].row  = re_r;
          jobs[njob[JOB_IDX_W-1:0]].col  = ce_r;
          jobs[njob[JOB_IDX_W-1:0]].done = 1'b1;
          njob = njob + (JOB_IDX_W+1)'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_LOAD) begin
      for (int i = 0; i < JOB_DEPTH; i++) jobs_r[i] <= jobs[i];
      njob_r <= njob;
    end
  end

  assign q_wr.push = (state_r == F_EMIT);
  assign q_job     = jobs_r[k_r];
  assign adv       = (state_r == F_EMIT) && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (state_r == F_LOAD) begin
      k_r <= '0;
    end else if (adv) begin
      k_r <= JOB_IDX_W'(k_r + JOB_IDX_W'(1));
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (push) state_nxt = F_LOAD;
      F_LOAD: state_nxt = (njob == '0) ? F_IDLE : F_EMIT;
      F_EMIT: begin
        if (adv && ((JOB_IDX_W+1)'(k_r) + (JOB_IDX_W+1)'(1) == njob_r)) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= F_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== sv/rgm_job_fifo.sv =====
// ----------------------------------------------------------------------------
// rgm_job_fifo - short job queue between front and back
// Four entries in registers, head shown combinationally.
// ----------------------------------------------------------------------------
module rgm_job_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  rgm_pkg::q_wr_t wr,
  input  rgm_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd,
  output logic          empty,
  output rgm_pkg::job_t rd_job
);
  import rgm_pkg::*;

  job_t                 mem_r [JOB_DEPTH];
  logic [JOB_IDX_W-1:0] wp_r, rp_r;
  logic [JOB_IDX_W:0]   cnt_r;
  logic                 do_wr, do_rd;

  assign full   = (cnt_r == (JOB_IDX_W+1)'(JOB_DEPTH));
  assign empty  = (cnt_r == '0);
  assign do_wr  = wr.push && !full;
  assign do_rd  = rd && !empty;
  assign rd_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= JOB_IDX_W'(wp_r + JOB_IDX_W'(1));
      if (do_rd) rp_r <= JOB_IDX_W'(rp_r + JOB_IDX_W'(1));
      case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + (JOB_IDX_W+1)'(1);
        2'b01:   cnt_r <= cnt_r - (JOB_IDX_W+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== sv/rgm_back.sv =====
// ----------------------------------------------------------------------------
// rgm_back - job execution and result register
// Pass jobs go straight to the result register; magnitude jobs take abs
// differences, square and sum, then an 8-step bitwise floor square root.
// ----------------------------------------------------------------------------
module rgm_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  rgm_pkg::job_t             q_job,
  output logic                      q_pop,
  output logic                      empty,
  input  logic                      pop,
  output logic [rgm_pkg::PIX_W-1:0] out_pixel_out,
  output logic [rgm_pkg::POS_W-1:0] out_row,
  output logic [rgm_pkg::POS_W-1:0] out_col,
  output logic                      out_frame_done
);
  import rgm_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_SQ   = 3'b010,
    B_ROOT = 3'b100
  } bstate_t;

  bstate_t state_r, state_nxt;

  logic             res_vld_r;
  logic [PIX_W-1:0] res_pix_r;
  logic [ROW_W-1:0] res_row_r;
  logic [COL_W-1:0] res_col_r;
  logic             res_done_r;

  logic [PIX_W-1:0] gx_r, gy_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic             done_r;
  logic [SUM_W-1:0] sum_r;
  logic [PIX_W-1:0] root_r, bit_r;

  logic             take;
  logic [PIX_W-1:0] gx, gy, trial, root_nxt;
  logic [2*PIX_W-1:0] trial_sq;
  logic             root_end;

  assign take  = (state_r == B_IDLE) && !q_empty && !res_vld_r;
  assign q_pop = take;

  assign gx = (q_job.op_a >= q_job.op_b) ? PIX_W'(q_job.op_a - q_job.op_b)
                                         : PIX_W'(q_job.op_b - q_job.op_a);
  assign gy = (q_job.op_c >= q_job.op_d) ? PIX_W'(q_job.op_c - q_job.op_d)
                                         : PIX_W'(q_job.op_d - q_job.op_c);

  assign trial    = root_r | bit_r;
  assign trial_sq = (2*PIX_W)'(trial) * (2*PIX_W)'(trial);
  // sum >= 2^16 means root >= 256: saturate
  assign root_nxt = sum_r[SUM_W-1] ? {PIX_W{1'b1}}
                  : ((trial_sq <= sum_r[2*PIX_W-1:0]) ? trial : root_r);
  assign root_end = sum_r[SUM_W-1] || bit_r[0];

  always_ff @(posedge clk) begin
    if (take) begin
      gx_r   <= gx;
      gy_r   <= gy;
      row_r  <= q_job.row;
      col_r  <= q_job.col;
      done_r <= q_job.done;
    end
    if (state_r == B_SQ) begin
      sum_r  <= SUM_W'((2*PIX_W)'(gx_r) * (2*PIX_W)'(gx_r))
              + SUM_W'((2*PIX_W)'(gy_r) * (2*PIX_W)'(gy_r));
      root_r <= '0;
      bit_r  <= {1'b1, {(PIX_W-1){1'b0}}};
    end
    if (state_r == B_ROOT) begin
      root_r <= root_nxt;
      bit_r  <= bit_r >> 1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (take && !q_job.mag) begin
      res_vld_r <= 1'b1;
    end else if (state_r == B_ROOT && root_end) begin
      res_vld_r <= 1'b1;
    end else if (pop) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !q_job.mag) begin
      res_pix_r  <= q_job.op_a;
      res_row_r  <= q_job.row;
      res_col_r  <= q_job.col;
      res_done_r <= q_job.done;
    end else if (state_r == B_ROOT && root_end) begin
      res_pix_r  <= root_nxt;
      res_row_r  <= row_r;
      res_col_r  <= col_r;
      res_done_r <= done_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (take && q_job.mag) state_nxt = B_SQ;
      B_SQ:   state_nxt = B_ROOT;
      B_ROOT: if (root_end) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else        state_r <= state_nxt;
  end

  assign empty          = !res_vld_r;
  assign out_pixel_out  = res_pix_r;
  assign out_row        = POS_W'(res_row_r);
  assign out_col        = POS_W'(res_col_r);
  assign out_frame_done = res_done_r;

endmodule

// ===== sv/roberts_gradient_magnitude.sv =====
// ----------------------------------------------------------------------------
// roberts_gradient_magnitude - Roberts cross edge magnitude over a pixel stream
// Line-buffered 2x2 gradient with floor square root, borders passed through.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive in_pixel_in with push high; the beat is taken
//   on a clock edge with full low. Pixels arrive in raster order.
//   Result side is a queue: while empty is low, out_* hold the oldest result;
//   assert pop to take it. out_frame_done marks the (H-1,W-1) result.
//   cfg_we/cfg_index/cfg_wdata write image_width (0) or image_height (1);
//   write only between frames with the block drained.
// Flow:
//   The front takes each pixel through a buffer read and a job build, then
//   pushes its jobs one at a time, waiting while the job queue is full; full
//   stays high until the last job is pushed. A pixel in row 0 or col 0
//   gives no result. The back turns a border job straight into a result;
//   a magnitude job goes through abs diff, square-sum and 8 root steps (one
//   8x8 multiply per step, cut short when the sum saturates). The next job
//   is taken only after the result register is popped, so the root unit
//   sets the steady rate for interior pixels. A result passes the front's
//   job build and the job queue, and a magnitude result also the root unit.
//   A stall on pop backs up the 4-deep job queue and then raises full.
// Reset (rst_n low, synchronous): counters, neighbor registers and queues
//   clear, dimensions return to 1024x1024. The line buffer is not cleared.
// ----------------------------------------------------------------------------
module roberts_gradient_magnitude (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rgm_pkg::REG_W-1:0]   cfg_index,
  input  logic [rgm_pkg::DIM_W-1:0]   cfg_wdata,
  input  logic                        push,
  output logic                        full,
  input  logic [rgm_pkg::PIX_W-1:0]   in_pixel_in,
  output logic                        empty,
  input  logic                        pop,
  output logic [rgm_pkg::PIX_W-1:0]   out_pixel_out,
  output logic [rgm_pkg::POS_W-1:0]   out_row,
  output logic [rgm_pkg::POS_W-1:0]   out_col,
  output logic                        out_frame_done
);
  import rgm_pkg::*;

  q_wr_t q_wr;
  job_t  wr_job, rd_job;
  logic  q_full, q_empty, q_pop;

  // front: position tracking, line buffer, job build
  rgm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .push        (push),
    .full        (full),
    .in_pixel_in (in_pixel_in),
    .q_wr        (q_wr),
    .q_full      (q_full),
    .q_job       (wr_job)
  );

  // decouples job build from the root unit
  rgm_job_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (q_wr),
    .wr_job (wr_job),
    .full   (q_full),
    .rd     (q_pop),
    .empty  (q_empty),
    .rd_job (rd_job)
  );

  // back: magnitude / pass-through and result register
  rgm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_job          (rd_job),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_pixel_out  (out_pixel_out),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_done (out_frame_done)
  );

endmodule
